// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the heap block. Every check runs on clk and is
// held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/imhdk_pkg.sv =====
// ----------------------------------------------------------------------------
// imhdk_pkg: shared constants and the key comparison of the indexed min-heap
// Port widths, parameter defaults and the lexicographic key order.
// ----------------------------------------------------------------------------
package imhdk_pkg;

  localparam int unsigned CELLS_DEF    = 4096;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned CELL_W       = 12;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Primary key first. The secondary key only decides a tie.
  function automatic logic key_lt(input logic [KEY_W-1:0] ap, input logic [KEY_W-1:0] as_,
                                  input logic [KEY_W-1:0] bp, input logic [KEY_W-1:0] bs);
    logic res;
    if (ap != bp) begin
      res = (ap < bp);
    end else begin
      res = (as_ < bs);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/imhdk_if.sv =====
// ----------------------------------------------------------------------------
// imhdk_cmd_if / imhdk_res_if: command and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface imhdk_cmd_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [imhdk_pkg::KEY_W-1:0]     key_primary;
  logic [imhdk_pkg::KEY_W-1:0]     key_secondary;
  logic [imhdk_pkg::CELL_W-1:0]    cell_index;

  modport source (output valid, cmd, key_primary, key_secondary, cell_index, input ready);
  modport sink   (input valid, cmd, key_primary, key_secondary, cell_index, output ready);
endinterface

interface imhdk_res_if;
  logic                            valid;
  logic                            ready;
  logic [imhdk_pkg::KEY_W-1:0]     out_key_primary;
  logic [imhdk_pkg::KEY_W-1:0]     out_key_secondary;
  logic [imhdk_pkg::CELL_W-1:0]    out_cell;
  logic                            was_empty;

  modport source (output valid, out_key_primary, out_key_secondary, out_cell, was_empty,
                  input ready);
  modport sink   (input valid, out_key_primary, out_key_secondary, out_cell, was_empty,
                  output ready);
endinterface

// ===== hw/rtl/imhdk_ram.sv =====
// ----------------------------------------------------------------------------
// imhdk_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module imhdk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/indexed_min_heap_decrease_key_top.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_top: indexed binary min-heap with decrease-key
// Operation: a push checks the position map, then climbs from its slot toward the root;
//   an update then also descends. A pop reads the root, then moves the last entry into
//   the root and sifts it down; a pop on an empty heap returns was_empty.
// Flow: one word at a time; a new word is taken only once the last is through. The
//   single heap read port sets the pace, and a pop also waits for a free result.
// Reset: synchronous, active low; then a clearing pass marks every position map
//   entry absent before the first word is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_min_heap_decrease_key_top #(
  parameter int unsigned CELLS    = imhdk_pkg::CELLS_DEF,
  parameter int unsigned KEY_BITS = imhdk_pkg::KEY_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  imhdk_cmd_if.sink    in_ch,
  imhdk_res_if.source  out_ch
);

  localparam int unsigned KW  = (KEY_BITS < imhdk_pkg::KEY_W) ? KEY_BITS : imhdk_pkg::KEY_W;
  localparam int unsigned CW  = imhdk_pkg::CELL_W;
  localparam int unsigned AW  = $clog2(CELLS);
  localparam int unsigned SW  = $clog2(CELLS + 1);
  localparam int unsigned EW  = 2 * KW + CW;
  localparam int unsigned MW  = AW + 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_PUSH_CHK, S_UP_RD, S_UP_CMP, S_DN_RD1, S_DN_RD2, S_DN_CMP,
    S_PLACE, S_POP, S_POP_ROOT, S_POP_LAST
  } state_t;

  state_t            state_r;
  logic [AW-1:0]     clr_r;
  logic [SW-1:0]     count_r;
  logic [AW-1:0]     slot_r;
  logic              dn_after_r;
  logic [KW-1:0]     ent_p_r, ent_s_r;
  logic [CW-1:0]     ent_c_r;
  logic [EW-1:0]     c1_r;
  logic              out_valid_r;
  logic [imhdk_pkg::KEY_W-1:0] out_p_r, out_s_r;
  logic [CW-1:0]     out_c_r;
  logic              out_e_r;

  // Heap and map memory ports.
  logic              h_we;
  logic [AW-1:0]     h_waddr, h_raddr;
  logic [EW-1:0]     h_wdata, h_rdata;
  logic              m_we;
  logic [AW-1:0]     m_waddr, m_raddr;
  logic [MW-1:0]     m_wdata, m_rdata;

  imhdk_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_heap (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata)
  );

  imhdk_ram #(.WIDTH(MW), .DEPTH(CELLS)) u_map (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );

  // Field views.
  logic [KW-1:0]     rd_p, rd_s, c1_p, c1_s, ch_p, ch_s;
  logic [CW-1:0]     rd_c, c1_c, ch_c;
  logic [31:0]       in_cell32, rd_c32, ch_c32, ent_c32;
  logic              in_cell_ok;
  logic [AW-1:0]     parent, kid_a, kid2_a, ch_slot;
  logic [SW:0]       kid, kid2;
  logic              has_kid, has_kid2, sel2, up_mv, dn_mv, out_free, out_load;
  logic [SW-1:0]     count_dec;

  assign {rd_p, rd_s, rd_c} = h_rdata;
  assign {c1_p, c1_s, c1_c} = c1_r;
  assign in_cell32  = 32'(in_ch.cell_index);
  assign rd_c32     = 32'(rd_c);
  assign ent_c32    = 32'(ent_c_r);
  assign in_cell_ok = in_cell32 < 32'(CELLS);
  assign parent     = (slot_r - AW'(1)) >> 1;
  assign kid        = ((SW + 1)'(slot_r) << 1) + (SW + 1)'(1);
  assign kid2       = kid + (SW + 1)'(1);
  assign kid_a      = kid[AW-1:0];
  assign kid2_a     = kid2[AW-1:0];
  assign has_kid    = kid < (SW + 1)'(count_r);
  assign has_kid2   = kid2 < (SW + 1)'(count_r);
  assign count_dec  = count_r - SW'(1);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign out_load   = ((state_r == S_POP) && out_free && (count_r == '0)) ||
                      (state_r == S_POP_ROOT);

  assign sel2    = has_kid2 && imhdk_pkg::key_lt(32'(rd_p), 32'(rd_s), 32'(c1_p), 32'(c1_s));
  assign ch_p    = sel2 ? rd_p : c1_p;
  assign ch_s    = sel2 ? rd_s : c1_s;
  assign ch_c    = sel2 ? rd_c : c1_c;
  assign ch_c32  = 32'(ch_c);
  assign ch_slot = sel2 ? kid2_a : kid_a;
  assign up_mv   = imhdk_pkg::key_lt(32'(ent_p_r), 32'(ent_s_r), 32'(rd_p), 32'(rd_s));
  assign dn_mv   = imhdk_pkg::key_lt(32'(ch_p), 32'(ch_s), 32'(ent_p_r), 32'(ent_s_r));

  assign m_raddr = in_cell32[AW-1:0];

  always_comb begin
    h_we    = 1'b0;
    h_waddr = slot_r;
    h_wdata = {ent_p_r, ent_s_r, ent_c_r};
    h_raddr = '0;
    m_we    = 1'b0;
    m_waddr = ent_c32[AW-1:0];
    m_wdata = {1'b1, slot_r};
    unique case (state_r)
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_r;
        m_wdata = '0;
      end
      S_UP_RD:  h_raddr = parent;
      S_UP_CMP: begin
        if (up_mv) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          m_we    = 1'b1;
          m_waddr = rd_c32[AW-1:0];
        end
      end
      S_DN_RD1: h_raddr = kid_a;
      S_DN_RD2: h_raddr = kid2_a;
      S_DN_CMP: begin
        if (dn_mv) begin
          h_we    = 1'b1;
          h_wdata = {ch_p, ch_s, ch_c};
          m_we    = 1'b1;
          m_waddr = ch_c32[AW-1:0];
        end
      end
      S_PLACE: begin
        h_we = 1'b1;
        m_we = 1'b1;
      end
      S_POP_ROOT: begin
        h_raddr = count_dec[AW-1:0];
        m_we    = 1'b1;
        m_waddr = rd_c32[AW-1:0];
        m_wdata = '0;
      end
      default: h_raddr = '0;
    endcase
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.out_key_primary   = out_p_r;
  assign out_ch.out_key_secondary = out_s_r;
  assign out_ch.out_cell          = out_c_r;
  assign out_ch.was_empty         = out_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      dn_after_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            ent_p_r <= in_ch.key_primary[KW-1:0];
            ent_s_r <= in_ch.key_secondary[KW-1:0];
            ent_c_r <= in_ch.cell_index;
            if (in_ch.cmd == imhdk_pkg::CMD_POP) begin
              state_r <= S_POP;
            end else if (in_cell_ok) begin
              state_r <= S_PUSH_CHK;
            end
          end
        end
        S_PUSH_CHK: begin
          state_r <= S_UP_RD;
          if (m_rdata[MW-1]) begin
            slot_r     <= m_rdata[AW-1:0];
            dn_after_r <= 1'b1;
          end else begin
            slot_r     <= count_r[AW-1:0];
            count_r    <= count_r + SW'(1);
            dn_after_r <= 1'b0;
          end
        end
        S_UP_RD: begin
          if (slot_r == '0) begin
            state_r <= dn_after_r ? S_DN_RD1 : S_PLACE;
          end else begin
            state_r <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (up_mv) begin
            slot_r  <= parent;
            state_r <= S_UP_RD;
          end else begin
            state_r <= dn_after_r ? S_DN_RD1 : S_PLACE;
          end
        end
        S_DN_RD1: state_r <= has_kid ? S_DN_RD2 : S_PLACE;
        S_DN_RD2: begin
          c1_r    <= h_rdata;
          state_r <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_mv) begin
            slot_r  <= ch_slot;
            state_r <= S_DN_RD1;
          end else begin
            state_r <= S_PLACE;
          end
        end
        S_PLACE: state_r <= S_IDLE;
        S_POP: begin
          if (out_free) begin
            if (count_r == '0) begin
              out_p_r     <= '1;
              out_s_r     <= '1;
              out_c_r     <= '0;
              out_e_r     <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_POP_ROOT;
            end
          end
        end
        S_POP_ROOT: begin
          // The output register was free in the previous cycle, in S_POP, and only a pop fills it.
          out_p_r     <= 32'(rd_p);
          out_s_r     <= 32'(rd_s);
          out_c_r     <= rd_c;
          out_e_r     <= 1'b0;
          count_r     <= count_dec;
          state_r     <= (count_dec == '0) ? S_IDLE : S_POP_LAST;
        end
        S_POP_LAST: begin
          {ent_p_r, ent_s_r, ent_c_r} <= h_rdata;
          slot_r     <= '0;
          dn_after_r <= 1'b1;
          state_r    <= S_DN_RD1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_SAME(a_count_bound, 1'b1, count_r <= SW'(CELLS), "heap count above capacity")
  `ASSERT_SAME(a_root_nonempty, state_r == S_POP_ROOT, count_r != '0, "root read on empty heap")
  `ASSERT_SAME(a_hole_in_heap, state_r == S_DN_RD1, SW'(slot_r) < count_r, "hole outside heap")

endmodule

// ===== tb/tb_indexed_min_heap_decrease_key_top.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_decrease_key_top: self-checking bench for the heap block
// Pushes, key updates and pops go in through a queue-fed driver. A local
// indexed heap predicts every popped word, and a monitor compares the words
// with it in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_decrease_key_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCELL = imhdk_pkg::CELLS_DEF;

  typedef struct packed {
    logic                         cmd;
    logic [imhdk_pkg::KEY_W-1:0]  kp;
    logic [imhdk_pkg::KEY_W-1:0]  ks;
    logic [imhdk_pkg::CELL_W-1:0] cidx;
  } cmd_word_t;

  typedef struct packed {
    logic [imhdk_pkg::KEY_W-1:0]  kp;
    logic [imhdk_pkg::KEY_W-1:0]  ks;
    logic [imhdk_pkg::CELL_W-1:0] cidx;
    logic                         empty;
  } pop_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  imhdk_cmd_if in_ch();
  imhdk_res_if out_ch();

  indexed_min_heap_decrease_key_top i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Local copy of the heap.
  logic [imhdk_pkg::KEY_W-1:0]  hp_pri [NCELL];
  logic [imhdk_pkg::KEY_W-1:0]  hp_sec [NCELL];
  logic [imhdk_pkg::CELL_W-1:0] hp_cell[NCELL];
  int unsigned       slot_of[NCELL];
  bit                present[NCELL];
  int unsigned       hp_count;

  cmd_word_t   pending_cmds[$];
  pop_word_t   expected_pops[$];
  int unsigned errors;
  int unsigned pops_seen;
  int unsigned empty_pops;
  int unsigned updates;
  bit          quiet;
  bit          hold_off;

  function automatic bit slot_lt(int unsigned a, int unsigned b);
    if (hp_pri[a] != hp_pri[b]) return hp_pri[a] < hp_pri[b];
    return hp_sec[a] < hp_sec[b];
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [imhdk_pkg::KEY_W-1:0]  tp;
    logic [imhdk_pkg::KEY_W-1:0]  ts;
    logic [imhdk_pkg::CELL_W-1:0] tc;
    tp = hp_pri[a];  ts = hp_sec[a];  tc = hp_cell[a];
    hp_pri[a] = hp_pri[b];  hp_sec[a] = hp_sec[b];  hp_cell[a] = hp_cell[b];
    hp_pri[b] = tp;  hp_sec[b] = ts;  hp_cell[b] = tc;
    slot_of[hp_cell[a]] = a;
    slot_of[hp_cell[b]] = b;
  endfunction

  function automatic int unsigned sift_up(int unsigned s);
    int unsigned p;
    while (s > 0) begin
      p = (s - 1) / 2;
      if (!slot_lt(s, p)) break;
      swap_slots(s, p);
      s = p;
    end
    return s;
  endfunction

  function automatic void sift_down(int unsigned s);
    int unsigned k;
    while (2 * s + 1 < hp_count) begin
      k = 2 * s + 1;
      if (k + 1 < hp_count && slot_lt(k + 1, k)) k++;
      if (!slot_lt(k, s)) return;
      swap_slots(s, k);
      s = k;
    end
  endfunction

  // Applies one accepted command word; a pop leaves its outcome in the queue.
  function automatic void apply_heap_cmd(cmd_word_t w);
    pop_word_t   r;
    int unsigned s;
    if (w.cmd == imhdk_pkg::CMD_PUSH) begin
      if (!present[w.cidx]) begin
        s = hp_count;
        hp_pri[s] = w.kp;  hp_sec[s] = w.ks;  hp_cell[s] = w.cidx;
        slot_of[w.cidx] = s;
        present[w.cidx] = 1'b1;
        hp_count++;
        void'(sift_up(s));
      end else begin
        s = slot_of[w.cidx];
        hp_pri[s] = w.kp;  hp_sec[s] = w.ks;
        updates++;
        sift_down(sift_up(s));
      end
    end else begin
      if (hp_count == 0) begin
        r = '{kp: '1, ks: '1, cidx: '0, empty: 1'b1};
      end else begin
        r = '{kp: hp_pri[0], ks: hp_sec[0], cidx: hp_cell[0], empty: 1'b0};
        present[hp_cell[0]] = 1'b0;
        hp_count--;
        if (hp_count > 0) begin
          hp_pri[0] = hp_pri[hp_count];  hp_sec[0] = hp_sec[hp_count];
          hp_cell[0] = hp_cell[hp_count];
          slot_of[hp_cell[0]] = 0;
          sift_down(0);
        end
      end
      expected_pops.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [imhdk_pkg::KEY_W-1:0] got,
                                 input logic [imhdk_pkg::KEY_W-1:0] want);
    $display("%0t: %s got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 14);
  endfunction

  // Driver: one word offered at a time, random gaps between words.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the word
    end else begin
      if (in_ch.valid) apply_heap_cmd(pending_cmds.pop_front());
      if (pending_cmds.size() > 0 && !hold_off && !idle_now()) begin
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= pending_cmds[0].cmd;
        in_ch.key_primary   <= pending_cmds[0].kp;
        in_ch.key_secondary <= pending_cmds[0].ks;
        in_ch.cell_index    <= pending_cmds[0].cidx;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each popped word against the oldest expectation.
  always @(posedge clk) begin
    pop_word_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        pops_seen++;
        if (expected_pops.size() == 0) begin
          report_mismatch("unexpected popped word, key_primary", out_ch.out_key_primary, '0);
        end else begin
          e = expected_pops.pop_front();
          if (e.empty) empty_pops++;
          if (out_ch.out_key_primary !== e.kp)
            report_mismatch("key_primary", out_ch.out_key_primary, e.kp);
          if (out_ch.out_key_secondary !== e.ks)
            report_mismatch("key_secondary", out_ch.out_key_secondary, e.ks);
          if (out_ch.out_cell !== e.cidx)
            report_mismatch("cell", imhdk_pkg::KEY_W'(out_ch.out_cell),
                            imhdk_pkg::KEY_W'(e.cidx));
          if (out_ch.was_empty !== e.empty)
            report_mismatch("was_empty", imhdk_pkg::KEY_W'(out_ch.was_empty),
                            imhdk_pkg::KEY_W'(e.empty));
        end
      end
      out_ch.ready <= !idle_now();
    end
  end

  function automatic logic [imhdk_pkg::KEY_W-1:0] rand_key();
    unique case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(7);
      3: return {16'($urandom_range(3)), 16'h0} | 32'($urandom_range(1));
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_cmd(logic c, logic [imhdk_pkg::KEY_W-1:0] p,
                                    logic [imhdk_pkg::KEY_W-1:0] s,
                                    logic [imhdk_pkg::CELL_W-1:0] cl);
    pending_cmds.push_back('{cmd: c, kp: p, ks: s, cidx: cl});
  endfunction

  initial begin
    int unsigned n;
    int unsigned span;
    int unsigned live;
    quiet = 1'b0;
    hold_off = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, extreme keys and cells, equal keys, key raise and lower.
    queue_cmd(imhdk_pkg::CMD_POP, '0, '0, '0);
    queue_cmd(imhdk_pkg::CMD_PUSH, '1, '1, 12'hfff);
    queue_cmd(imhdk_pkg::CMD_PUSH, '0, '0, 12'h000);
    queue_cmd(imhdk_pkg::CMD_PUSH, 32'h5, 32'h9, 12'h010);
    queue_cmd(imhdk_pkg::CMD_PUSH, 32'h5, 32'h9, 12'h011);
    queue_cmd(imhdk_pkg::CMD_PUSH, 32'h5, 32'h2, 12'h012);
    queue_cmd(imhdk_pkg::CMD_PUSH, '1, '0, 12'h000);
    queue_cmd(imhdk_pkg::CMD_PUSH, 32'h5, 32'h1, 12'hfff);
    queue_cmd(imhdk_pkg::CMD_PUSH, 32'h0, 32'hffff_fffe, 12'h011);
    queue_cmd(imhdk_pkg::CMD_PUSH, 32'haaaa_5555, 32'h5555_aaaa, 12'haaa);
    queue_cmd(imhdk_pkg::CMD_PUSH, 32'h5555_aaaa, 32'haaaa_5555, 12'h555);
    repeat (8) queue_cmd(imhdk_pkg::CMD_POP, '0, '0, '0);

    // Mostly build-up then drain runs, so the heap goes deep before emptying.
    n = pending_cmds.size();
    while (n < 1850) begin
      span = $urandom_range(3) == 0 ? $urandom_range(4095) : $urandom_range(63);
      live = 0;
      // A run of pushes mixed with pops; cells fall in a random range, so some pushes are updates.
      repeat ($urandom_range(60, 1)) begin
        if ($urandom_range(9) < 7) begin
          queue_cmd(imhdk_pkg::CMD_PUSH, rand_key(), rand_key(),
                    imhdk_pkg::CELL_W'($urandom_range(span)));
          live++;
        end else begin
          queue_cmd(imhdk_pkg::CMD_POP, $urandom, $urandom, imhdk_pkg::CELL_W'($urandom));
        end
        n++;
      end
      repeat ($urandom_range(live + 2)) begin
        queue_cmd(imhdk_pkg::CMD_POP, $urandom, $urandom, imhdk_pkg::CELL_W'($urandom));
        n++;
      end
    end
    queue_cmd(imhdk_pkg::CMD_PUSH, 32'h7, 32'h7, 12'h123);
    repeat (2) queue_cmd(imhdk_pkg::CMD_POP, '0, '0, '0);

    // Hold the sender until the heap's pops have all come back, then a quiet stretch.
    wait (pending_cmds.size() < 1200);
    hold_off = 1'b1;
    @(posedge clk);
    while (in_ch.valid || expected_pops.size() > 0) @(posedge clk);
    hold_off = 1'b0;
    wait (pending_cmds.size() < 900);
    quiet = 1'b1;
    wait (pending_cmds.size() < 600);
    quiet = 1'b0;

    wait (pending_cmds.size() == 0);
    @(posedge clk);
    while (in_ch.valid || expected_pops.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Ran %0d pops (%0d on an empty heap) and %0d key updates;",
             pops_seen, empty_pops, updates);
    $display("%0d words left in the heap at the end.", hp_count);
    if (errors == 0) begin
      $display("indexed_min_heap_decrease_key_top: match");
    end else begin
      $display("indexed_min_heap_decrease_key_top: mismatch");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("indexed_min_heap_decrease_key_top: mismatch");
    $finish;
  end

endmodule
